[sv/isqm_pkg.sv]
// isqm_pkg: shared constants, seed table and the divider stage type
// used by isqm_div_stage and integer_sqrt_and_magnitude; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package isqm_pkg;

  localparam int unsigned OperandW   = 32;
  localparam int unsigned CompW      = 16;
  localparam int unsigned RootW      = 16;
  localparam int unsigned ShW        = 4;   // half of the normalising shift
  localparam int unsigned DivisorW   = 9;   // seed plus one, 128 to 256
  localparam int unsigned DivStages  = 4;
  localparam int unsigned DivSteps   = 4;   // quotient bits per stage
  localparam int unsigned SeedDepth  = 192;
  localparam int unsigned SeedIdxW   = 8;
  localparam logic [SeedIdxW-1:0] SeedIdxMax  = 8'd191;
  localparam logic [SeedIdxW-1:0] SeedIdxBase = 8'd64;

  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_MAG  = 1'b1
  } isqm_op_e;

  // one item inside the divider pipeline
  typedef struct packed {
    logic [DivisorW-1:0] rem;
    logic [RootW-1:0]    num;
    logic [RootW-1:0]    quot;
    logic [DivisorW-1:0] dvs;
    logic [OperandW-1:0] xn;
    logic [ShW-1:0]      sh;
    logic                zero;
  } isqm_div_t;

  localparam logic [7:0] SEED_TABLE [SeedDepth] = '{
    8'd127, 8'd128, 8'd129, 8'd130, 8'd131, 8'd132, 8'd133, 8'd134, 8'd135, 8'd136,
    8'd137, 8'd138, 8'd139, 8'd140, 8'd141, 8'd142, 8'd143, 8'd143, 8'd144, 8'd145,
    8'd146, 8'd147, 8'd148, 8'd149, 8'd150, 8'd150, 8'd151, 8'd152, 8'd153, 8'd154,
    8'd155, 8'd155, 8'd156, 8'd157, 8'd158, 8'd159, 8'd159, 8'd160, 8'd161, 8'd162,
    8'd163, 8'd163, 8'd164, 8'd165, 8'd166, 8'd167, 8'd167, 8'd168, 8'd169, 8'd170,
    8'd170, 8'd171, 8'd172, 8'd173, 8'd173, 8'd174, 8'd175, 8'd175, 8'd176, 8'd177,
    8'd178, 8'd178, 8'd179, 8'd180, 8'd181, 8'd181, 8'd182, 8'd183, 8'd183, 8'd184,
    8'd185, 8'd185, 8'd186, 8'd187, 8'd187, 8'd188, 8'd189, 8'd189, 8'd190, 8'd191,
    8'd191, 8'd192, 8'd193, 8'd193, 8'd194, 8'd195, 8'd195, 8'd196, 8'd197, 8'd197,
    8'd198, 8'd199, 8'd199, 8'd200, 8'd201, 8'd201, 8'd202, 8'd203, 8'd203, 8'd204,
    8'd204, 8'd205, 8'd206, 8'd206, 8'd207, 8'd207, 8'd208, 8'd209, 8'd209, 8'd210,
    8'd211, 8'd211, 8'd212, 8'd212, 8'd213, 8'd214, 8'd214, 8'd215, 8'd215, 8'd216,
    8'd217, 8'd217, 8'd218, 8'd218, 8'd219, 8'd219, 8'd220, 8'd221, 8'd221, 8'd222,
    8'd222, 8'd223, 8'd223, 8'd224, 8'd225, 8'd225, 8'd226, 8'd226, 8'd227, 8'd227,
    8'd228, 8'd229, 8'd229, 8'd230, 8'd230, 8'd231, 8'd231, 8'd232, 8'd232, 8'd233,
    8'd234, 8'd234, 8'd235, 8'd235, 8'd236, 8'd236, 8'd237, 8'd237, 8'd238, 8'd238,
    8'd239, 8'd239, 8'd240, 8'd241, 8'd241, 8'd242, 8'd242, 8'd243, 8'd243, 8'd244,
    8'd244, 8'd245, 8'd245, 8'd246, 8'd246, 8'd247, 8'd247, 8'd248, 8'd248, 8'd249,
    8'd249, 8'd250, 8'd250, 8'd251, 8'd251, 8'd252, 8'd252, 8'd253, 8'd253, 8'd254,
    8'd254, 8'd255
  };

endpackage

`default_nettype wire

[sv/isqm_div_stage.sv]
// isqm_div_stage: one registered stage of the restoring divider,
// several quotient bits per stage; depends on isqm_pkg
`timescale 1ns / 1ps
`default_nettype none

module isqm_div_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire isqm_pkg::isqm_div_t data_i,
  output logic                     valid_o,
  output isqm_pkg::isqm_div_t      data_o
);
  import isqm_pkg::*;

  isqm_div_t data_d, data_q;
  logic      valid_q;

  always_comb begin
    logic [DivisorW:0] trial;
    data_d = data_i;
    for (int s = 0; s < DivSteps; s++) begin
      trial = {data_d.rem, data_d.num[RootW-1]};
      data_d.num = {data_d.num[RootW-2:0], 1'b0};
      if (trial >= {1'b0, data_d.dvs}) begin
        trial = trial - {1'b0, data_d.dvs};
        data_d.quot = {data_d.quot[RootW-2:0], 1'b1};
      end else begin
        data_d.quot = {data_d.quot[RootW-2:0], 1'b0};
      end
      // remainder stays below the divisor
      data_d.rem = trial[DivisorW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[sv/integer_sqrt_and_magnitude.sv]
// integer_sqrt_and_magnitude: pipelined floor square root of a 32-bit value
// or of a*a+b*b; depends on isqm_pkg and isqm_div_stage
`timescale 1ns / 1ps
`default_nettype none

// channel    ports                                   transaction
// command    start, busy, op_i, value_i,             start high, busy low
//            comp_a_i, comp_b_i
// result     valid_o, root_o                         valid_o high for one cycle
//
// one transaction per cycle, each carried through the stage registers to valid_o
// the throughput is set by the four divider stages and the squaring
// multipliers, each of which takes a new operand every cycle
// reset clears only the valid bits; data registers carry no reset
// the receiver cannot stall, so busy stays low and nothing ever waits

module integer_sqrt_and_magnitude (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          op_i,
  input  wire logic [isqm_pkg::OperandW-1:0] value_i,
  input  wire logic signed [isqm_pkg::CompW-1:0] comp_a_i,
  input  wire logic signed [isqm_pkg::CompW-1:0] comp_b_i,
  output logic                               valid_o,
  output logic [isqm_pkg::RootW-1:0]         root_o
);
  import isqm_pkg::*;

  // stage valid bits: squares, operand, shift search, seed, then after divider
  logic v1_q, v2_q, v3_q, v4_q, v9_q, v10_q, v11_q;

  // stage 1: component squares
  logic signed [2*CompW-1:0] sq_a_full, sq_b_full;
  logic [2*CompW-2:0]        sq_a_q, sq_b_q;
  logic [OperandW-1:0]       val1_q;
  isqm_op_e                  op1_q;

  // stage 2: selected operand
  logic [OperandW-1:0] x_d, x2_q;

  // stage 3: pair search for the normalising shift
  logic [ShW-1:0]      sh_d, sh3_q;
  logic [OperandW-1:0] x3_q;
  logic                zero3_q;

  // stage 4: normalise and seed
  logic [OperandW-1:0] xn_d;
  logic [SeedIdxW-1:0] idx_raw, idx;
  logic [DivisorW-1:0] seed_d;
  isqm_div_t           div_in_q;

  // divider chain
  isqm_div_t div_s [DivStages+1];
  logic      div_v [DivStages+1];

  // stages 9 to 11: refine, square, correct and shift back
  logic [RootW-1:0]     y1_d, y9_q, y10_q;
  logic [OperandW-1:0]  xn9_q, xn10_q, ysq_q;
  logic [ShW-1:0]       sh9_q, sh10_q;
  logic                 zero9_q, zero10_q;
  logic [RootW-1:0]     y2, root_d, root_q;

  // no back-pressure anywhere in the pipeline
  assign busy = 1'b0;

  assign sq_a_full = comp_a_i * comp_a_i;
  assign sq_b_full = comp_b_i * comp_b_i;

  // squares of 16-bit values are at most 2^30, sum at most 2^31
  assign x_d = (op1_q == OP_MAG) ? ({1'b0, sq_a_q} + {1'b0, sq_b_q}) : val1_q;

  // last assignment wins, so the highest nonzero pair sets the count
  always_comb begin
    sh_d = '0;
    for (int p = 0; p < OperandW/2; p++) begin
      if (x2_q[2*p +: 2] != 2'b00) begin
        sh_d = ShW'(OperandW/2 - 1 - p);
      end
    end
  end

  // top byte of a nonzero normalised word is at least 64
  always_comb begin
    xn_d    = x3_q << {sh3_q, 1'b0};
    idx_raw = xn_d[OperandW-1 -: SeedIdxW] - SeedIdxBase;
    idx     = (idx_raw > SeedIdxMax) ? SeedIdxMax : idx_raw;
    seed_d  = {1'b0, SEED_TABLE[idx]} + DivisorW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
    end else begin
      v1_q  <= start && !busy;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v9_q  <= div_v[DivStages];
      v10_q <= v9_q;
      v11_q <= v10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_a_q  <= sq_a_full[2*CompW-2:0];
    sq_b_q  <= sq_b_full[2*CompW-2:0];
    val1_q  <= value_i;
    op1_q   <= isqm_op_e'(op_i);
    x2_q    <= x_d;
    x3_q    <= x2_q;
    sh3_q   <= sh_d;
    zero3_q <= (x2_q == '0);
    // the top seven bits of (xn >> 9) are below any divisor
    div_in_q.rem  <= {2'b00, xn_d[OperandW-1 -: 7]};
    div_in_q.num  <= xn_d[OperandW-8 -: RootW];
    div_in_q.quot <= '0;
    div_in_q.dvs  <= seed_d;
    div_in_q.xn   <= xn_d;
    div_in_q.sh   <= sh3_q;
    div_in_q.zero <= zero3_q;
  end

  assign div_s[0] = div_in_q;
  assign div_v[0] = v4_q;

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    isqm_div_stage u_div_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_v[g]),
      .data_i  (div_s[g]),
      .valid_o (div_v[g+1]),
      .data_o  (div_s[g+1])
    );
  end

  // estimate is seed*128 plus quotient, kept to 16 bits
  assign y1_d = {div_s[DivStages].dvs, 7'b0} + div_s[DivStages].quot;

  // one below when the square overshoots, then undo the normalisation
  always_comb begin
    y2     = (xn10_q < ysq_q) ? (y10_q - RootW'(1)) : y10_q;
    root_d = zero10_q ? '0 : (y2 >> sh10_q);
  end

  always_ff @(posedge clk_i) begin
    y9_q     <= y1_d;
    xn9_q    <= div_s[DivStages].xn;
    sh9_q    <= div_s[DivStages].sh;
    zero9_q  <= div_s[DivStages].zero;
    ysq_q    <= y9_q * y9_q;
    y10_q    <= y9_q;
    xn10_q   <= xn9_q;
    sh10_q   <= sh9_q;
    zero10_q <= zero9_q;
    root_q   <= root_d;
  end

  assign valid_o = v11_q;
  assign root_o  = root_q;

endmodule

`default_nettype wire

[sv/isqm_checker.sv]
// isqm_checker: port-level checks of the square root block, bound to
// integer_sqrt_and_magnitude; depends on isqm_pkg
`timescale 1ns / 1ps
`default_nettype none

module isqm_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          op_i,
  input wire logic [isqm_pkg::OperandW-1:0] value_i,
  input wire logic signed [isqm_pkg::CompW-1:0] comp_a_i,
  input wire logic signed [isqm_pkg::CompW-1:0] comp_b_i,
  input wire logic                          valid_o,
  input wire logic [isqm_pkg::RootW-1:0]    root_o
);
  import isqm_pkg::*;

  logic acc;
  assign acc = start && !busy;

  // every accepted transaction yields a result on valid_o
  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##11 valid_o)
    else $error("result missing after accepted transaction");

  // no result without an accepted transaction
  a_latency_bwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(acc, 11))
    else $error("result without transaction");

  // zero operand or zero pair gives zero root
  a_zero_root : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && ((!op_i && value_i == '0) ||
             (op_i && comp_a_i == '0 && comp_b_i == '0))) |-> ##11 (root_o == '0))
    else $error("nonzero root of zero");

  // magnitude of 16-bit components never exceeds the root of 2^31
  a_mag_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && op_i) |-> ##11 (root_o <= 16'd46340))
    else $error("magnitude out of range");

endmodule

bind integer_sqrt_and_magnitude isqm_checker u_isqm_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .op_i     (op_i),
  .value_i  (value_i),
  .comp_a_i (comp_a_i),
  .comp_b_i (comp_b_i),
  .valid_o  (valid_o),
  .root_o   (root_o)
);

`default_nettype wire

[bench/testbench.sv]
// testbench for integer_sqrt_and_magnitude: drives root and magnitude transactions
// and checks every root against an in-bench predictor; depends on isqm_pkg
`timescale 1ns / 1ps

module testbench;

  import isqm_pkg::*;

  // the pipeline's stated depth, used for the settle time at the end of each test
  localparam int unsigned PIPE_LATENCY = 11;
  localparam int unsigned SETTLE_CYCLES = PIPE_LATENCY + 4;
  // watchdog limit, far beyond the slowest correct run
  localparam longint unsigned TIMEOUT_NS = 64'd5_000_000;
  localparam int unsigned MAX_PRINTED = 20;
  localparam int unsigned RANDOM_ITEMS = 330;

  // seed lookup: entry i holds the approximate root for top byte 64 + i
  localparam logic [31:0] SEED_BASE       = 32'd64;
  localparam logic [31:0] SEED_LAST       = 32'd191;
  localparam int unsigned EVEN_SHIFT_MASK = 30;
  localparam logic [7:0] ROOT_SEEDS [192] = '{
    8'd127, 8'd128, 8'd129, 8'd130, 8'd131, 8'd132, 8'd133, 8'd134, 8'd135, 8'd136,
    8'd137, 8'd138, 8'd139, 8'd140, 8'd141, 8'd142, 8'd143, 8'd143, 8'd144, 8'd145,
    8'd146, 8'd147, 8'd148, 8'd149, 8'd150, 8'd150, 8'd151, 8'd152, 8'd153, 8'd154,
    8'd155, 8'd155, 8'd156, 8'd157, 8'd158, 8'd159, 8'd159, 8'd160, 8'd161, 8'd162,
    8'd163, 8'd163, 8'd164, 8'd165, 8'd166, 8'd167, 8'd167, 8'd168, 8'd169, 8'd170,
    8'd170, 8'd171, 8'd172, 8'd173, 8'd173, 8'd174, 8'd175, 8'd175, 8'd176, 8'd177,
    8'd178, 8'd178, 8'd179, 8'd180, 8'd181, 8'd181, 8'd182, 8'd183, 8'd183, 8'd184,
    8'd185, 8'd185, 8'd186, 8'd187, 8'd187, 8'd188, 8'd189, 8'd189, 8'd190, 8'd191,
    8'd191, 8'd192, 8'd193, 8'd193, 8'd194, 8'd195, 8'd195, 8'd196, 8'd197, 8'd197,
    8'd198, 8'd199, 8'd199, 8'd200, 8'd201, 8'd201, 8'd202, 8'd203, 8'd203, 8'd204,
    8'd204, 8'd205, 8'd206, 8'd206, 8'd207, 8'd207, 8'd208, 8'd209, 8'd209, 8'd210,
    8'd211, 8'd211, 8'd212, 8'd212, 8'd213, 8'd214, 8'd214, 8'd215, 8'd215, 8'd216,
    8'd217, 8'd217, 8'd218, 8'd218, 8'd219, 8'd219, 8'd220, 8'd221, 8'd221, 8'd222,
    8'd222, 8'd223, 8'd223, 8'd224, 8'd225, 8'd225, 8'd226, 8'd226, 8'd227, 8'd227,
    8'd228, 8'd229, 8'd229, 8'd230, 8'd230, 8'd231, 8'd231, 8'd232, 8'd232, 8'd233,
    8'd234, 8'd234, 8'd235, 8'd235, 8'd236, 8'd236, 8'd237, 8'd237, 8'd238, 8'd238,
    8'd239, 8'd239, 8'd240, 8'd241, 8'd241, 8'd242, 8'd242, 8'd243, 8'd243, 8'd244,
    8'd244, 8'd245, 8'd245, 8'd246, 8'd246, 8'd247, 8'd247, 8'd248, 8'd248, 8'd249,
    8'd249, 8'd250, 8'd250, 8'd251, 8'd251, 8'd252, 8'd252, 8'd253, 8'd253, 8'd254,
    8'd254, 8'd255
  };

  // one expected root with the operand kept for the mismatch message
  typedef struct {
    isqm_op_e          op;
    logic [OperandW-1:0] operand;
    logic [RootW-1:0]  root;
  } root_expect_t;

  logic                       clk_i    = 1'b0;
  logic                       rst_ni   = 1'b0;
  logic                       start    = 1'b0;
  logic                       op_i     = 1'b0;
  logic [OperandW-1:0]        value_i  = '0;
  logic signed [CompW-1:0]    comp_a_i = '0;
  logic signed [CompW-1:0]    comp_b_i = '0;
  logic                       busy;
  logic                       valid_o;
  logic [RootW-1:0]           root_o;

  root_expect_t  pending_roots [$];
  root_expect_t  oldest_root;
  int unsigned   mismatch_count = 0;
  int unsigned   roots_checked  = 0;
  int unsigned   sqrt_sent      = 0;
  int unsigned   mag_sent       = 0;
  int unsigned   sender_idle_pct = 0;
  // set once start has been lowered for the current time step, so it is never
  // given a second nonblocking assignment in the same step
  bit            sender_quiet = 1'b1;

  integer_sqrt_and_magnitude u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .op_i     (op_i),
    .value_i  (value_i),
    .comp_a_i (comp_a_i),
    .comp_b_i (comp_b_i),
    .valid_o  (valid_o),
    .root_o   (root_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // exact a*a + b*b; the largest case (-32768, -32768) is 2^31 and still fits
  function automatic logic [OperandW-1:0] sum_of_squares(
    input logic signed [CompW-1:0] a,
    input logic signed [CompW-1:0] b
  );
    logic signed [OperandW:0] wa;
    logic signed [OperandW:0] wb;
    wa = (OperandW+1)'(a);
    wb = (OperandW+1)'(b);
    return OperandW'(wa * wa + wb * wb);
  endfunction

  // table-seeded root: normalise by an even shift, seed, one divide step,
  // correct an overshoot by one, then undo half the shift
  function automatic logic [RootW-1:0] floor_root_of(input logic [OperandW-1:0] x);
    int unsigned lz;
    int unsigned sh;
    logic [31:0] xn;
    logic [31:0] idx;
    logic [31:0] y;
    if (x == '0) begin
      return '0;
    end
    lz = 0;
    while (!x[31 - lz]) begin
      lz++;
    end
    sh  = lz & EVEN_SHIFT_MASK;
    xn  = x << sh;
    idx = ((xn >> 24) - SEED_BASE) & 32'hFF;
    if (idx > SEED_LAST) begin
      idx = SEED_LAST;
    end
    y = 32'(ROOT_SEEDS[idx]) + 32'd1;
    y = ((y << 7) + (xn >> 9) / y) & 32'hFFFF;
    if (64'(xn) < 64'(y) * 64'(y)) begin
      y = (y - 32'd1) & 32'hFFFF;
    end
    return RootW'(y >> (sh >> 1));
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting and result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // the receiver cannot stall, so every strobe is a result transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($isunknown(valid_o)) begin
        report_mismatch("result strobe is unknown");
      end else if (valid_o) begin
        if (pending_roots.size() == 0) begin
          report_mismatch($sformatf("root %0d with no transaction waiting", root_o));
        end else begin
          oldest_root = pending_roots.pop_front();
          roots_checked++;
          if (root_o !== oldest_root.root) begin
            report_mismatch($sformatf("%s of %0d: root %0d, wanted %0d",
                                      oldest_root.op.name(), oldest_root.operand,
                                      root_o, oldest_root.root));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------

  // offer one transaction and hold it until accepted; after acceptance the
  // sender may go quiet for a while, putting junk on the unused data ports
  // each following cycle is idle with the chosen percentage
  task automatic send_transaction(
    input isqm_op_e                op,
    input logic [OperandW-1:0]     value,
    input logic signed [CompW-1:0] a,
    input logic signed [CompW-1:0] b
  );
    root_expect_t want;
    int unsigned  gap;
    want.op      = op;
    want.operand = (op == OP_MAG) ? sum_of_squares(a, b) : value;
    want.root    = floor_root_of(want.operand);
    start    <= 1'b1;
    op_i     <= op;
    value_i  <= value;
    comp_a_i <= a;
    comp_b_i <= b;
    sender_quiet = 1'b0;
    do begin
      @(posedge clk_i);
    end while (busy !== 1'b0);
    pending_roots.push_back(want);
    if (op == OP_MAG) begin
      mag_sent++;
    end else begin
      sqrt_sent++;
    end
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      start    <= 1'b0;
      op_i     <= 1'($urandom);
      value_i  <= $urandom;
      comp_a_i <= CompW'($urandom);
      comp_b_i <= CompW'($urandom);
      sender_quiet = 1'b1;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering, let every outstanding root come back, then let the pipe settle
  task automatic wait_for_all_roots();
    if (!sender_quiet) begin
      start <= 1'b0;
      sender_quiet = 1'b1;
    end
    while (pending_roots.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // random operands, biased towards every normalising shift and near-squares
  // ---------------------------------------------------------------------------

  function automatic logic [OperandW-1:0] random_operand();
    logic [31:0] r;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: begin
        r = $urandom_range(0, 65535);
        return r * r + 32'($urandom_range(0, 2)) - 32'd1;
      end
      default: begin
        r = 32'd1 << $urandom_range(0, 31);
        return $urandom_range(0, 1) ? r : r - 32'd1;
      end
    endcase
  endfunction

  function automatic logic signed [CompW-1:0] random_component();
    case ($urandom_range(0, 3))
      0, 1: return CompW'($urandom);
      2: return $urandom_range(0, 1) ? CompW'($urandom_range(0, 255))
                                     : -CompW'($urandom_range(0, 255));
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          default: return -16'sh0001;
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero, one, full scale, both sides of the even normalisation boundary and
  // the largest perfect square
  task automatic test_sqrt_corners();
    logic [OperandW-1:0] corners [10];
    corners = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                32'h3FFF_FFFF, 32'h4000_0000, 32'h8000_0000, 32'hFFFE_0000,
                32'hFFFE_0001, 32'hFFFF_FFFF};
    foreach (corners[i]) begin
      send_transaction(OP_SQRT, corners[i], random_component(), random_component());
    end
    wait_for_all_roots();
  endtask

  // zero pair, the most negative pair (sum 2^31), full positive, mixed signs
  task automatic test_magnitude_corners();
    send_transaction(OP_MAG, $urandom, 16'sh0000, 16'sh0000);
    send_transaction(OP_MAG, $urandom, 16'sh8000, 16'sh8000);
    send_transaction(OP_MAG, $urandom, 16'sh7FFF, 16'sh7FFF);
    send_transaction(OP_MAG, $urandom, 16'sh8000, 16'sh0000);
    send_transaction(OP_MAG, $urandom, 16'sh0000, 16'sh7FFF);
    send_transaction(OP_MAG, $urandom, 16'sh0003, -16'sh0004);
    send_transaction(OP_MAG, $urandom, -16'sh0001, -16'sh0001);
    send_transaction(OP_MAG, $urandom, 16'sh8000, 16'sh7FFF);
    wait_for_all_roots();
  endtask

  // whichever operand the op does not select must have no effect
  task automatic test_ignored_fields();
    send_transaction(OP_SQRT, 32'd0, 16'sh8000, 16'sh8000);
    send_transaction(OP_SQRT, 32'd49, 16'sh7FFF, -16'sh0001);
    send_transaction(OP_MAG, 32'hFFFF_FFFF, 16'sh0000, 16'sh0000);
    send_transaction(OP_MAG, 32'hFFFF_FFFF, 16'sh0005, 16'sh000C);
    wait_for_all_roots();
  endtask

  // mixed traffic with a pause until drained half way through
  task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct);
    isqm_op_e op;
    sender_idle_pct = idle_pct;
    for (int unsigned n = 0; n < count; n++) begin
      op = isqm_op_e'($urandom_range(0, 1));
      send_transaction(op, random_operand(), random_component(), random_component());
      if (n == count / 2) begin
        wait_for_all_roots();
      end
    end
    wait_for_all_roots();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 20;
    test_sqrt_corners();
    test_magnitude_corners();
    test_ignored_fields();

    test_random_traffic(RANDOM_ITEMS, 20);
    test_random_traffic(RANDOM_ITEMS, 51);
    test_random_traffic(RANDOM_ITEMS, 0);

    if (pending_roots.size() != 0) begin
      report_mismatch($sformatf("%0d roots never arrived", pending_roots.size()));
    end
    $display("covered %0d square-root and %0d magnitude transactions, %0d roots checked",
             sqrt_sent, mag_sent, roots_checked);
    $display("sender quiet 20, 51 and 0 percent of the time, drained between tests");
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog against a hung handshake or lost results
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d roots outstanding", pending_roots.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

[integer_sqrt_and_magnitude.f]
sv/isqm_pkg.sv
sv/isqm_div_stage.sv
sv/integer_sqrt_and_magnitude.sv
sv/isqm_checker.sv
bench/testbench.sv
